>>> rtl/aes_pkg.sv
`timescale 1ns / 1ps

package aes_pkg;

	// one write beat into the round key store
	typedef struct packed {
		logic        we;
		logic [3:0]  row;
		logic [1:0]  col;
		logic [31:0] word;
	} kwr_t;

	typedef logic [3:0][63:0] key_regs_t;

	// key length codes
	localparam logic [1:0] KL_128 = 2'd0;
	localparam logic [1:0] KL_192 = 2'd1;
	localparam logic [1:0] KL_256 = 2'd2;

	localparam logic [7:0] RC_FIRST = 8'h01;
	localparam logic [7:0] GF_POLY  = 8'h1b;

	localparam logic [7:0] SBOX_FWD [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? GF_POLY : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
	endfunction

	// key words: 4, 6 or 8; the unused code acts as 256-bit
	function automatic logic [3:0] key_words(input logic [1:0] kl);
		case (kl)
			KL_128:  return 4'd4;
			KL_192:  return 4'd6;
			default: return 4'd8;
		endcase
	endfunction

endpackage

>>> rtl/aes_key_mem.sv
`timescale 1ns / 1ps

module aes_key_mem
	import aes_pkg::*;
(
	input  logic         clk,
	input  kwr_t         kwr,
	input  logic         re,
	input  logic [3:0]   raddr,
	output logic [127:0] rdata
);

	// one row per round key, column 0 in the top lane
	logic [3:0][31:0] mem [15];

	// word write into one lane
	always_ff @(posedge clk) begin
		if (kwr.we) begin
			mem[kwr.row][~kwr.col] <= kwr.word;
		end
	end

	// registered row read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/aes_key_exp.sv
`timescale 1ns / 1ps

module aes_key_exp
	import aes_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] key_length,
	input  key_regs_t  keys,
	output kwr_t       kwr,
	output logic       done
);

	logic        busy_q;
	logic [5:0]  idx_q;
	logic [2:0]  kpos_q;
	logic [7:0]  rc_q;
	logic [31:0] win_q [8];

	logic [3:0]  nk;
	logic [5:0]  total;
	logic [31:0] key_word;
	logic [31:0] prev;
	logic [31:0] old;
	logic [31:0] sw_in;
	logic [31:0] sw_out;
	logic [31:0] t;
	logic [31:0] word;
	logic        in_key;
	logic        last;

	assign nk     = key_words(key_length);
	assign total  = {nk, 2'b00} + 6'd28;
	assign in_key = idx_q < {2'b00, nk};
	assign last   = idx_q == total - 6'd1;

	// user key words straight from the registers
	assign key_word = idx_q[0] ? keys[idx_q[2:1]][31:0] : keys[idx_q[2:1]][63:32];

	// schedule recurrence on the sliding window
	assign prev   = win_q[0];
	assign old    = win_q[3'(nk - 4'd1)];
	assign sw_in  = (kpos_q == 3'd0) ? {prev[23:0], prev[31:24]} : prev;
	assign sw_out = sub_word(sw_in);

	always_comb begin
		t = prev;
		if (kpos_q == 3'd0) begin
			t = sw_out ^ {rc_q, 24'h0};
		end else if (nk == 4'd8 && kpos_q == 3'd4) begin
			t = sw_out;
		end
		word = in_key ? key_word : (old ^ t);
	end

	assign kwr.we   = busy_q;
	assign kwr.row  = idx_q[5:2];
	assign kwr.col  = idx_q[1:0];
	assign kwr.word = word;
	assign done     = busy_q && last;

	// word counter and round constant
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			kpos_q <= '0;
			rc_q   <= RC_FIRST;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
			kpos_q <= '0;
			rc_q   <= RC_FIRST;
		end else if (busy_q) begin
			idx_q  <= idx_q + 6'd1;
			kpos_q <= ({1'b0, kpos_q} == nk - 4'd1) ? 3'd0 : kpos_q + 3'd1;
			if (!in_key && kpos_q == 3'd0) begin
				rc_q <= xtime(rc_q);
			end
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	// last eight words, newest first
	always_ff @(posedge clk) begin
		if (busy_q) begin
			win_q[0] <= word;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

endmodule

>>> rtl/aes_round.sv
`timescale 1ns / 1ps

module aes_round
	import aes_pkg::*;
(
	input  logic         decrypt,
	input  logic         first,
	input  logic         last,
	input  logic [127:0] state,
	input  logic [127:0] rk,
	output logic [127:0] next
);

	logic [7:0] s   [16];
	logic [7:0] k   [16];
	logic [7:0] es  [16];
	logic [7:0] em  [16];
	logic [7:0] di  [16];
	logic [7:0] da  [16];
	logic [7:0] dm  [16];
	logic [7:0] a0, a1, a2, a3;
	logic [7:0] x2 [4];
	logic [7:0] x4 [4];
	logic [7:0] x8 [4];
	logic [7:0] c  [4];

	always_comb begin
		for (int j = 0; j < 16; j++) begin
			s[j] = state[127 - 8*j -: 8];
			k[j] = rk[127 - 8*j -: 8];
		end

		// forward: sub bytes then shift rows
		for (int cc = 0; cc < 4; cc++) begin
			for (int r = 0; r < 4; r++) begin
				es[cc*4 + r] = SBOX_FWD[s[((cc + r) & 3)*4 + r]];
			end
		end

		// forward mix columns
		for (int cc = 0; cc < 4; cc++) begin
			a0 = es[cc*4];
			a1 = es[cc*4 + 1];
			a2 = es[cc*4 + 2];
			a3 = es[cc*4 + 3];
			em[cc*4]     = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
			em[cc*4 + 1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
			em[cc*4 + 2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
			em[cc*4 + 3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
		end

		// inverse shift rows and inverse sub bytes, then key add
		for (int cc = 0; cc < 4; cc++) begin
			for (int r = 0; r < 4; r++) begin
				di[((cc + r) & 3)*4 + r] = SBOX_INV[s[cc*4 + r]];
			end
		end
		for (int j = 0; j < 16; j++) begin
			da[j] = di[j] ^ k[j];
		end

		// inverse mix columns with 9, 11, 13, 14
		for (int cc = 0; cc < 4; cc++) begin
			for (int r = 0; r < 4; r++) begin
				c[r]  = da[cc*4 + r];
				x2[r] = xtime(c[r]);
				x4[r] = xtime(x2[r]);
				x8[r] = xtime(x4[r]);
			end
			for (int r = 0; r < 4; r++) begin
				dm[cc*4 + r] = (x8[r] ^ x4[r] ^ x2[r])
					^ (x8[(r+1)&3] ^ x2[(r+1)&3] ^ c[(r+1)&3])
					^ (x8[(r+2)&3] ^ x4[(r+2)&3] ^ c[(r+2)&3])
					^ (x8[(r+3)&3] ^ c[(r+3)&3]);
			end
		end

		// pick the round flavor
		for (int j = 0; j < 16; j++) begin
			if (first) begin
				next[127 - 8*j -: 8] = s[j] ^ k[j];
			end else if (decrypt) begin
				next[127 - 8*j -: 8] = last ? da[j] : dm[j];
			end else begin
				next[127 - 8*j -: 8] = (last ? es[j] : em[j]) ^ k[j];
			end
		end
	end

endmodule

>>> rtl/aes_block_cipher_core.sv
`timescale 1ns / 1ps
// AES block cipher core, one block at a time (ECB style)
// Input channel: in_valid / in_stall carry op (0 encrypt, 1 decrypt) and the
// 128-bit block as block_hi / block_lo, byte 0 in the top bits of block_hi.
// Output channel: out_valid / out_stall carry result_hi / result_lo.
// Key setup: cfg_we writes register cfg_index with cfg_data: 0 key length
// (0 = 128, 1 = 192, 2 or 3 = 256 bit), 1..4 key bytes 0..31. Write only while
// idle. Any key write makes the next block expand the round keys first.
// Rounds: Nr = 10, 12 or 14. A block runs one key row read, Nr+1 round steps
// (one round per cycle from the round key memory) and one output load into
// the output register. The first block after reset or a key write first runs
// key expansion of 4*(Nr+1) key words, one key word per cycle into the round
// key memory.
// in_stall is high while a block is in flight; the next block is taken as
// soon as the result moves to the output register, even while out_stall holds
// it. With the output register full and stalled, the finished block waits.
// Reset: key length 256, key zero, round keys invalid, both channels empty.

module aes_block_cipher_core
	import aes_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
	localparam logic [2:0] CFG_KEY_LAST   = 3'd4;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXPAND = 3'd1;
	localparam logic [2:0] ST_KEYRD  = 3'd2;
	localparam logic [2:0] ST_RUN    = 3'd3;
	localparam logic [2:0] ST_HOLD   = 3'd4;

	logic [2:0]   fsm_q;
	logic [1:0]   key_len_q;
	key_regs_t    key_q;
	logic         keys_ready_q;
	logic         op_q;
	logic [127:0] blk_q;
	logic [3:0]   step_q;
	logic         out_valid_q;
	logic [127:0] result_q;

	logic         in_beat;
	logic         exp_start;
	logic         exp_done;
	kwr_t         kwr;
	logic         rd_en;
	logic [3:0]   rd_addr;
	logic [127:0] rk;
	logic [127:0] round_out;
	logic [3:0]   nr;
	logic [3:0]   step_next;
	logic [1:0]   key_sel;
	logic         out_free;

	assign nr        = key_words(key_len_q) + 4'd6;
	assign in_stall  = fsm_q != ST_IDLE;
	assign in_beat   = in_valid && !in_stall;
	assign exp_start = in_beat && !keys_ready_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign step_next = step_q + 4'd1;
	assign key_sel   = cfg_index[1:0] - 2'd1;

	// round key row for the step after the current one
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		if (fsm_q == ST_KEYRD) begin
			rd_en   = 1'b1;
			rd_addr = op_q ? nr : 4'd0;
		end else if (fsm_q == ST_RUN && step_q != nr) begin
			rd_en   = 1'b1;
			rd_addr = op_q ? nr - step_next : step_next;
		end
	end

	aes_key_exp u_key_exp (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (exp_start),
		.key_length (key_len_q),
		.keys       (key_q),
		.kwr        (kwr),
		.done       (exp_done)
	);

	aes_key_mem u_key_mem (
		.clk   (clk),
		.kwr   (kwr),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rk)
	);

	aes_round u_round (
		.decrypt (op_q),
		.first   (step_q == 4'd0),
		.last    (step_q == nr),
		.state   (blk_q),
		.rk      (rk),
		.next    (round_out)
	);

	// key registers and round key status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_len_q    <= KL_256;
			key_q        <= '0;
			keys_ready_q <= 1'b0;
		end else if (cfg_we && cfg_index <= CFG_KEY_LAST) begin
			keys_ready_q <= 1'b0;
			if (cfg_index == CFG_KEY_LENGTH) begin
				key_len_q <= cfg_data[1:0];
			end else begin
				key_q[key_sel] <= cfg_data;
			end
		end else if (exp_done) begin
			keys_ready_q <= 1'b1;
		end
	end

	// block sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (fsm_q)
				ST_IDLE: begin
					if (in_beat) begin
						fsm_q <= keys_ready_q ? ST_KEYRD : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (exp_done) begin
						fsm_q <= ST_KEYRD;
					end
				end
				ST_KEYRD: begin
					step_q <= '0;
					fsm_q  <= ST_RUN;
				end
				ST_RUN: begin
					step_q <= step_next;
					if (step_q == nr) begin
						fsm_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						fsm_q       <= ST_IDLE;
					end
				end
				default: fsm_q <= ST_IDLE;
			endcase
		end
	end

	// block state and result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			op_q  <= op;
			blk_q <= {block_hi, block_lo};
		end else if (fsm_q == ST_RUN) begin
			blk_q <= round_out;
		end
		if (fsm_q == ST_HOLD && out_free) begin
			result_q <= blk_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_hi = result_q[127:64];
	assign result_lo = result_q[63:0];

	// a result beat only appears after the hold step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fsm_q) == ST_HOLD)
		else $error("result beat without a finished block");

	// round step never passes the round count
	assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == ST_RUN |-> step_q <= nr)
		else $error("round step beyond round count");

	// a key write invalidates the expanded keys
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index <= CFG_KEY_LAST |=> !keys_ready_q)
		else $error("round keys still marked ready after key write");

	// a block never starts rounds on stale keys
	assert property (@(posedge clk) disable iff (!arst_n)
		fsm_q == ST_KEYRD |-> keys_ready_q)
		else $error("round key read before expansion finished");

	// expansion only runs when a block is waiting for it
	assert property (@(posedge clk) disable iff (!arst_n)
		kwr.we |-> fsm_q == ST_EXPAND)
		else $error("key store written outside expansion");

endmodule

>>> tb/sv/tb_aes_block_cipher_core.sv
`timescale 1ns / 1ps

module tb_aes_block_cipher_core;
	import aes_pkg::*;

	// register indexes of the key setup port
	localparam logic [2:0] REG_KEY_LEN = 3'd0;
	localparam logic [2:0] REG_KEY_0   = 3'd1;
	localparam logic [2:0] REG_KEY_1   = 3'd2;
	localparam logic [2:0] REG_KEY_2   = 3'd3;
	localparam logic [2:0] REG_KEY_3   = 3'd4;
	localparam logic [2:0] REG_SPARE   = 3'd5;
	localparam logic [1:0] KL_SPARE    = 2'd3;

	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	localparam int NUM_PHASES  = 12;
	localparam int HOLD_PHASE  = 3;
	localparam int CALM_PHASE  = 6;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 14;

	typedef struct {
		logic        op;
		logic [63:0] hi;
		logic [63:0] lo;
	} block_beat_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [63:0] block_hi;
	logic [63:0] block_lo;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] result_hi;
	logic [63:0] result_lo;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	aes_block_cipher_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .block_hi(block_hi), .block_lo(block_lo),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_hi(result_hi), .result_lo(result_lo),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state: key registers and expanded schedule
	logic [1:0]  mdl_key_len;
	logic [63:0] mdl_key [4];
	logic [31:0] sched [60];
	logic        sched_ok;

	block_beat_t  block_queue[$];
	logic [127:0] expected_blocks[$];
	int           mismatches;
	int           phase_no;
	logic         in_took;

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] gf_double(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [3:0] m);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int k = 0; k < 4; k++) begin
			if (m[k]) acc ^= x;
			x = gf_double(x);
		end
		return acc;
	endfunction

	function automatic int nk_words();
		return mdl_key_len == KL_128 ? 4 : (mdl_key_len == KL_192 ? 6 : 8);
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] w);
		return {SBOX_FWD[w[31:24]], SBOX_FWD[w[23:16]], SBOX_FWD[w[15:8]], SBOX_FWD[w[7:0]]};
	endfunction

	// key schedule into the 60-word store
	function automatic void expand_schedule();
		int nk;
		logic [31:0] t;
		logic [7:0] rc;
		nk = nk_words();
		rc = 8'h01;
		for (int i = 0; i < nk; i++)
			sched[i] = i[0] ? mdl_key[i >> 1][31:0] : mdl_key[i >> 1][63:32];
		for (int i = nk; i < 4 * (nk + 7); i++) begin
			t = sched[i - 1];
			if (i % nk == 0) begin
				t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
				rc = gf_double(rc);
			end else if (nk > 6 && i % nk == 4) begin
				t = sbox_word(t);
			end
			sched[i] = sched[i - nk] ^ t;
		end
		sched_ok = 1'b1;
	endfunction

	// byte i of the state lives at bits 127-8i
	function automatic logic [127:0] add_rk(input logic [127:0] s, input int rnd);
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = sched[(rnd * 4 + c) % 60];
			s[127 - 32 * c -: 32] ^= w;
		end
		return s;
	endfunction

	function automatic logic [127:0] sub_all(input logic [127:0] s, input logic inv);
		for (int i = 0; i < 16; i++)
			s[127 - 8 * i -: 8] = inv ? SBOX_INV[s[127 - 8 * i -: 8]] : SBOX_FWD[s[127 - 8 * i -: 8]];
		return s;
	endfunction

	function automatic logic [127:0] shift_all(input logic [127:0] s, input logic inv);
		logic [127:0] t;
		t = s;
		for (int r = 1; r < 4; r++)
			for (int c = 0; c < 4; c++) begin
				if (inv)
					s[127 - 8 * (((c + r) & 3) * 4 + r) -: 8] = t[127 - 8 * (c * 4 + r) -: 8];
				else
					s[127 - 8 * (c * 4 + r) -: 8] = t[127 - 8 * (((c + r) & 3) * 4 + r) -: 8];
			end
		return s;
	endfunction

	function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
		logic [3:0] mat [4];
		logic [7:0] col [4];
		logic [7:0] acc;
		if (inv) mat = '{4'd14, 4'd11, 4'd13, 4'd9};
		else mat = '{4'd2, 4'd3, 4'd1, 4'd1};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) col[k] = s[127 - 8 * (c * 4 + k) -: 8];
			for (int r = 0; r < 4; r++) begin
				acc = 8'h00;
				for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], mat[(k - r) & 3]);
				s[127 - 8 * (c * 4 + r) -: 8] = acc;
			end
		end
		return s;
	endfunction

	// full cipher or inverse cipher on one block
	function automatic logic [127:0] aes_predict(input block_beat_t b);
		logic [127:0] s;
		int nr;
		if (!sched_ok) expand_schedule();
		nr = nk_words() + 6;
		s = {b.hi, b.lo};
		if (b.op == OP_ENC) begin
			s = add_rk(s, 0);
			for (int r = 1; r < nr; r++)
				s = add_rk(mix_all(shift_all(sub_all(s, 1'b0), 1'b0), 1'b0), r);
			s = add_rk(shift_all(sub_all(s, 1'b0), 1'b0), nr);
		end else begin
			s = add_rk(s, nr);
			for (int r = nr - 1; r > 0; r--)
				s = mix_all(add_rk(sub_all(shift_all(s, 1'b1), 1'b1), r), 1'b1);
			s = add_rk(sub_all(shift_all(s, 1'b1), 1'b1), 0);
		end
		return s;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// key setup write, mirrored into the predictor
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_KEY_LEN) begin
			mdl_key_len = val[1:0];
			sched_ok = 1'b0;
		end else if (idx <= REG_KEY_3) begin
			mdl_key[idx - 1] = val;
			sched_ok = 1'b0;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(9))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_block(input logic o, input logic [63:0] h, input logic [63:0] l);
		block_beat_t b;
		b.op = o;
		b.hi = h;
		b.lo = l;
		block_queue.push_back(b);
	endtask

	task automatic wait_drained();
		while (block_queue.size() != 0 || in_valid || expected_blocks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// sender: next beat once the current one is taken
	always @(negedge clk) begin
		if (!in_valid || in_took) begin
			if (block_queue.size() != 0 &&
					(phase_no == CALM_PHASE || $urandom_range(99) >= IDLE_PCT)) begin
				in_valid <= 1'b1;
				op <= block_queue[0].op;
				block_hi <= block_queue[0].hi;
				block_lo <= block_queue[0].lo;
				void'(block_queue.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold to back the block up
	int  hold_left;
	logic hold_done;
	always @(negedge clk) begin
		if (phase_no == HOLD_PHASE && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= phase_no != CALM_PHASE && $urandom_range(99) < IDLE_PCT;
		end
	end

	// input beats feed the predictor, output beats are checked
	always @(posedge clk) begin
		block_beat_t b;
		logic [127:0] want;
		in_took <= in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			b.op = op;
			b.hi = block_hi;
			b.lo = block_lo;
			expected_blocks.push_back(aes_predict(b));
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("unexpected result_hi", result_hi, 64'h0);
			end else begin
				want = expected_blocks.pop_front();
				if (result_hi !== want[127:64])
					report_mismatch("result_hi", result_hi, want[127:64]);
				if (result_lo !== want[63:0])
					report_mismatch("result_lo", result_lo, want[63:0]);
			end
		end
	end

	// stimulus phases
	initial begin
		logic [1:0] kl;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ENC;
		block_hi = '0;
		block_lo = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_KEY_LEN;
		cfg_data = '0;
		in_took = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		mismatches = 0;
		phase_no = 0;
		mdl_key_len = KL_256;
		for (int i = 0; i < 4; i++) mdl_key[i] = '0;
		sched_ok = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// reset key: zero 256-bit, field extremes both ways
		queue_block(OP_ENC, 64'h0, 64'h0);
		queue_block(OP_DEC, 64'h0, 64'h0);
		queue_block(OP_ENC, '1, '1);
		queue_block(OP_DEC, '1, '1);
		queue_block(OP_ENC, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
		queue_block(OP_DEC, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
		wait_drained();

		// known 256-bit vector, then each key length on its known key
		write_reg(REG_KEY_0, 64'h0001020304050607);
		write_reg(REG_KEY_1, 64'h08090a0b0c0d0e0f);
		write_reg(REG_KEY_2, 64'h1011121314151617);
		write_reg(REG_KEY_3, 64'h18191a1b1c1d1e1f);
		queue_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		queue_block(OP_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
		wait_drained();
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_KEY_LEN, 64'(k));
			queue_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
			queue_block(OP_DEC, '1, 64'h0);
			queue_block(OP_ENC, 64'h0, '1);
			wait_drained();
		end
		// unknown register index leaves the key alone
		write_reg(REG_SPARE, '1);
		write_reg(3'd7, 64'h1234);
		queue_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		wait_drained();

		// random blocks over a series of key settings
		for (int p = 1; p <= NUM_PHASES; p++) begin
			kl = (p == 2) ? KL_SPARE : 2'(p % 3);
			write_reg(REG_KEY_LEN, {$urandom, $urandom} & ~64'h3 | 64'(kl));
			for (int i = 0; i < 4; i++) begin
				if (p == 4) write_reg(REG_KEY_0 + 3'(i), '1);
				else if (p == 5) write_reg(REG_KEY_0 + 3'(i), '0);
				else write_reg(REG_KEY_0 + 3'(i), {$urandom, $urandom});
			end
			if ($urandom_range(1)) write_reg(3'($urandom_range(5, 7)), {$urandom, $urandom});
			phase_no = p;
			for (int n = 0; n < 120; n++)
				queue_block(1'($urandom), rand_word(), rand_word());
			wait_drained();
		end

		if (mismatches == 0) begin
			$display("aes_block_cipher_core: match");
		end else begin
			$display("aes_block_cipher_core: mismatch");
		end
		$finish;
	end

	// overall time limit
	initial begin
		#50_000_000;
		$display("aes_block_cipher_core: mismatch");
		$finish;
	end

endmodule

>>> files.f
rtl/aes_pkg.sv
rtl/aes_key_mem.sv
rtl/aes_key_exp.sv
rtl/aes_round.sv
rtl/aes_block_cipher_core.sv
tb/sv/tb_aes_block_cipher_core.sv
